// ----- hdl/tss_pkg.sv -----
// Shared types and constants of the TCP splice sequence rewriter.
`default_nettype none

package tss_pkg;

	// TCP option kinds and lengths that the option walk acts on.
	localparam logic [7:0] OPT_KIND_END    = 8'd0;
	localparam logic [7:0] OPT_KIND_PAD    = 8'd1;
	localparam logic [7:0] OPT_KIND_SACK   = 8'd5;
	localparam logic [7:0] OPT_KIND_TSTAMP = 8'd8;
	localparam logic [7:0] OPT_LEN_TSTAMP  = 8'd10;
	localparam logic [7:0] SACK_PAIR_LEN   = 8'd8;
	localparam logic [7:0] SACK_MIN_LEN    = 8'd10;

	// Fixed header positions.
	localparam logic [5:0] POS_SEQ_FIRST   = 6'd4;
	localparam logic [5:0] POS_ACK_FIRST   = 6'd8;
	localparam logic [5:0] POS_ACK_END     = 6'd12;
	localparam logic [5:0] POS_DATA_OFFSET = 6'd12;
	localparam logic [5:0] POS_FLAGS       = 6'd13;
	localparam logic [5:0] POS_OPTIONS     = 6'd20;
	localparam logic [5:0] POS_MAX         = 6'd63;
	localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

	// One accepted input beat.
	typedef struct packed {
		logic [7:0]  hdr_byte;
		logic        byte_last;
		logic        from_origin;
		logic [31:0] origin_seq_offset;
		logic [31:0] reverse_seq_offset;
		logic [31:0] origin_ts_offset;
		logic [31:0] reverse_ts_offset;
	} hdr_beat_t;

	// Group of up to four result bytes, left aligned, made from one input beat.
	typedef struct packed {
		logic        emit;
		logic [31:0] word;
		logic [2:0]  cnt;
		logic        last;
		logic        err;
	} res_group_t;

endpackage

`default_nettype wire

// ----- hdl/tss_in_if.sv -----
// Input channel: one TCP header byte per beat with direction and flow offsets.
`default_nettype none

interface tss_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  hdr_byte;
	logic        byte_last;
	logic        from_origin;
	logic [31:0] origin_seq_offset;
	logic [31:0] reverse_seq_offset;
	logic [31:0] origin_ts_offset;
	logic [31:0] reverse_ts_offset;

	modport source (
		output valid, hdr_byte, byte_last, from_origin, origin_seq_offset,
			reverse_seq_offset, origin_ts_offset, reverse_ts_offset,
		input ready
	);
	modport sink (
		input valid, hdr_byte, byte_last, from_origin, origin_seq_offset,
			reverse_seq_offset, origin_ts_offset, reverse_ts_offset,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/tss_out_if.sv -----
// Output channel: one rewritten header byte per beat.
`default_nettype none

interface tss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       options_error;

	modport source (
		output valid, out_byte, out_last, options_error,
		input ready
	);
	modport sink (
		input valid, out_byte, out_last, options_error,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/tss_parser.sv -----
// Header parser: position tracking, option walk, field hold and 32-bit rewrite.
`default_nettype none

module tss_parser import tss_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire hdr_beat_t  beat,
	input  wire logic       accept,
	output res_group_t      grp
);

	typedef enum logic [1:0] {
		PH_KIND = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2,
		PH_STOP = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2
	} rw_op_t;

	logic [5:0]  byte_cnt_q;
	logic [3:0]  hdr_words_q;
	logic        ack_seen_q;
	logic        syn_seen_q;
	phase_t      phase_q;
	logic [7:0]  opt_kind_q;
	logic [7:0]  opt_len_q;
	logic [5:0]  opt_pos_q;
	logic [31:0] hold_word_q;
	logic [1:0]  hold_cnt_q;
	logic        broken_q;

	logic [3:0]  hdr_words_d;
	logic        ack_seen_d;
	logic        syn_seen_d;
	phase_t      phase_d;
	logic [7:0]  opt_kind_d;
	logic [7:0]  opt_len_d;
	logic [5:0]  opt_pos_d;
	logic        broken_d;

	rw_op_t      op;
	logic [31:0] arg;
	logic [5:0]  hlen;
	logic [5:0]  remaining;
	logic [7:0]  rem_plus;
	logic [2:0]  sack_rest;
	logic [31:0] word_v;
	logic [31:0] word_rw;
	logic [31:0] word_al;
	logic [2:0]  k;
	logic [7:0]  b;
	logic        ts_opt;
	logic        sack_opt;

	// Parse step: select the rewrite operation and advance the option walk.
	always_comb begin
		b           = beat.hdr_byte;
		op          = OP_NONE;
		arg         = '0;
		hdr_words_d = hdr_words_q;
		ack_seen_d  = ack_seen_q;
		syn_seen_d  = syn_seen_q;
		phase_d     = phase_q;
		opt_kind_d  = opt_kind_q;
		opt_len_d   = opt_len_q;
		opt_pos_d   = opt_pos_q;
		broken_d    = broken_q;

		if (byte_cnt_q >= POS_SEQ_FIRST && byte_cnt_q < POS_ACK_FIRST) begin
			op  = beat.from_origin ? OP_ADD : OP_SUB;
			arg = beat.from_origin ? beat.origin_seq_offset : beat.reverse_seq_offset;
		end else if (byte_cnt_q >= POS_ACK_FIRST && byte_cnt_q < POS_ACK_END) begin
			op  = beat.from_origin ? OP_ADD : OP_SUB;
			arg = beat.from_origin ? beat.reverse_seq_offset : beat.origin_seq_offset;
		end else if (byte_cnt_q == POS_DATA_OFFSET) begin
			hdr_words_d = b[7:4];
		end else if (byte_cnt_q == POS_FLAGS) begin
			ack_seen_d = b[4];
			syn_seen_d = b[1];
		end

		hlen      = (hdr_words_q >= MIN_HEADER_WORDS) ? {hdr_words_q, 2'b00} : POS_OPTIONS;
		remaining = hlen - byte_cnt_q;
		rem_plus  = {2'b00, remaining} + 8'd1;
		// The SACK body is a whole number of edge pairs when the length ends in 2 mod 8.
		sack_rest = opt_len_q[2:0] - 3'd2;
		ts_opt    = (opt_kind_q == OPT_KIND_TSTAMP) &&
			(opt_len_q == OPT_LEN_TSTAMP);
		sack_opt  = (opt_kind_q == OPT_KIND_SACK) && !syn_seen_q &&
			(opt_len_q >= SACK_MIN_LEN) && (sack_rest == 3'd0);

		// Option area walk.
		if (byte_cnt_q >= POS_OPTIONS && byte_cnt_q < hlen && phase_q != PH_STOP) begin
			case (phase_q)
				PH_KIND: begin
					if (b == OPT_KIND_END) begin
						phase_d = PH_STOP;
					end else if (b == OPT_KIND_PAD) begin
						phase_d = PH_KIND;
					end else if (remaining < 6'd2) begin
						broken_d = 1'b1;
						phase_d  = PH_STOP;
					end else begin
						opt_kind_d = b;
						phase_d    = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b < 8'd2 || b > rem_plus) begin
						broken_d = 1'b1;
						phase_d  = PH_STOP;
					end else begin
						opt_len_d = b;
						opt_pos_d = 6'd2;
						phase_d   = (b == 8'd2) ? PH_KIND : PH_BODY;
					end
				end
				default: begin
					if (ts_opt) begin
						if (opt_pos_q < 6'd6) begin
							op  = OP_SUB;
							arg = beat.from_origin ? beat.origin_ts_offset
								: beat.reverse_ts_offset;
						end else if (ack_seen_q) begin
							op  = OP_ADD;
							arg = beat.from_origin ? beat.reverse_ts_offset
								: beat.origin_ts_offset;
						end
					end else if (sack_opt) begin
						op  = beat.from_origin ? OP_ADD : OP_SUB;
						arg = beat.from_origin ? beat.reverse_seq_offset
							: beat.origin_seq_offset;
					end
					opt_pos_d = opt_pos_q + 6'd1;
					if ({2'b00, opt_pos_d} == opt_len_q) begin
						phase_d = PH_KIND;
					end
				end
			endcase
		end
	end

	// Result group: held bytes plus this byte, rewritten when a field completes.
	always_comb begin
		word_v  = {hold_word_q[23:0], b};
		k       = {1'b0, hold_cnt_q} + 3'd1;
		word_rw = (op == OP_ADD) ? word_v + arg : word_v - arg;
		case (k)
			3'd1:    word_al = {word_v[7:0], 24'd0};
			3'd2:    word_al = {word_v[15:0], 16'd0};
			3'd3:    word_al = {word_v[23:0], 8'd0};
			default: word_al = word_v;
		endcase
		grp.emit = (op == OP_NONE) || (k == 3'd4) || beat.byte_last;
		grp.word = (op != OP_NONE && k == 3'd4) ? word_rw : word_al;
		grp.cnt  = k;
		grp.last = beat.byte_last;
		grp.err  = beat.byte_last && broken_d;
	end

	// Held bytes carry no reset; only bytes written in this packet are sent.
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_word_q <= word_v;
		end
	end

	// Per-packet state, cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			hdr_words_q <= '0;
			ack_seen_q  <= 1'b0;
			syn_seen_q  <= 1'b0;
			phase_q     <= PH_KIND;
			opt_kind_q  <= '0;
			opt_len_q   <= '0;
			opt_pos_q   <= '0;
			hold_cnt_q  <= '0;
			broken_q    <= 1'b0;
		end else if (accept) begin
			if (beat.byte_last) begin
				byte_cnt_q  <= '0;
				hdr_words_q <= '0;
				ack_seen_q  <= 1'b0;
				syn_seen_q  <= 1'b0;
				phase_q     <= PH_KIND;
				opt_kind_q  <= '0;
				opt_len_q   <= '0;
				opt_pos_q   <= '0;
				hold_cnt_q  <= '0;
				broken_q    <= 1'b0;
			end else begin
				if (byte_cnt_q != POS_MAX) begin
					byte_cnt_q <= byte_cnt_q + 6'd1;
				end
				hdr_words_q <= hdr_words_d;
				ack_seen_q  <= ack_seen_d;
				syn_seen_q  <= syn_seen_d;
				phase_q     <= phase_d;
				opt_kind_q  <= opt_kind_d;
				opt_len_q   <= opt_len_d;
				opt_pos_q   <= opt_pos_d;
				hold_cnt_q  <= grp.emit ? 2'd0 : k[1:0];
				broken_q    <= broken_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tss_out_stage.sv -----
// Result register: holds one group of up to four bytes and sends them one per beat.
`default_nettype none

module tss_out_stage import tss_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire res_group_t grp,
	input  wire logic       load,
	output logic            free,
	tss_out_if.source       res
);

	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	logic        err_q;
	logic        pop;
	logic        final_byte;

	// The register can take a new group when empty or when its last byte leaves now.
	assign final_byte        = (cnt_q == 3'd1);
	assign pop               = res.valid && res.ready;
	assign free              = (cnt_q == 3'd0) || (final_byte && res.ready);
	assign res.valid         = (cnt_q != 3'd0);
	assign res.out_byte      = word_q[31:24];
	assign res.out_last      = last_q && final_byte;
	assign res.options_error = err_q && final_byte;

	// Payload shifts left by one byte per beat taken.
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= grp.word;
			last_q <= grp.last;
			err_q  <= grp.err;
		end else if (pop) begin
			word_q <= {word_q[23:0], 8'd0};
		end
	end

	// Count of bytes still to send.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tcp_splice_seq_rewriter.sv -----
// Top level of the TCP splice sequence and option rewriter.
//
//   channel | dir | beat payload
//   --------+-----+--------------------------------------------------------
//   hdr     | in  | hdr_byte, byte_last, from_origin, four 32-bit offsets
//   res     | out | out_byte, out_last, options_error
//
// Each input byte is parsed in the cycle it is accepted; the group of zero to
// four bytes it yields sits in the result register from the next cycle and
// leaves at one byte per beat. A byte that only joins a held field is taken
// even while a group drains, so aligned 32-bit fields keep one byte per cycle
// while res does not stall. A byte that makes a group waits until the last byte
// of the previous group leaves, so a group right behind a four-byte group stalls
// hdr while that group drains. Reset clears the parse state and empties the result
// register. A stall on res holds the group and back-pressures hdr.
`default_nettype none

module tcp_splice_seq_rewriter import tss_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tss_in_if.sink    hdr,
	tss_out_if.source res
);

	hdr_beat_t  beat;
	res_group_t grp;
	logic       free;
	logic       accept;

	// Gather the input payload.
	always_comb begin
		beat.hdr_byte           = hdr.hdr_byte;
		beat.byte_last          = hdr.byte_last;
		beat.from_origin        = hdr.from_origin;
		beat.origin_seq_offset  = hdr.origin_seq_offset;
		beat.reverse_seq_offset = hdr.reverse_seq_offset;
		beat.origin_ts_offset   = hdr.origin_ts_offset;
		beat.reverse_ts_offset  = hdr.reverse_ts_offset;
	end

	// A beat that produces no bytes never needs room in the result register.
	assign hdr.ready = free || !grp.emit;
	assign accept    = hdr.valid && hdr.ready;

	tss_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.accept (accept),
		.grp    (grp)
	);

	tss_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.grp    (grp),
		.load   (accept && grp.emit),
		.free   (free),
		.res    (res)
	);

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench of the TCP splice rewriter: packet stimulus, byte-level prediction and checking.
import tss_pkg::*;

// Predicts the rewritten header bytes and checks the result channel against them.
class rewrite_tracker;
	typedef enum logic [1:0] {WALK_KIND, WALK_LEN, WALK_BODY, WALK_DONE} walk_e;
	typedef enum logic [1:0] {FIELD_PASS, FIELD_ADD, FIELD_SUB} field_op_e;
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} out_beat_t;

	// Per-packet parse state.
	logic [5:0]  byte_count;
	logic [3:0]  header_words;
	logic        ack_seen;
	logic        syn_seen;
	walk_e       walk;
	logic [7:0]  opt_kind;
	logic [7:0]  opt_len;
	logic [5:0]  opt_pos;
	logic [31:0] held;
	int unsigned held_cnt;
	logic        broken;

	out_beat_t   expected_bytes[$];
	int unsigned errors;
	int unsigned bytes_in;
	int unsigned bytes_out;
	int unsigned packets;
	int unsigned broken_packets;
	int unsigned fields_rewritten;

	function new();
		clear_packet();
		errors = 0;
		bytes_in = 0;
		bytes_out = 0;
		packets = 0;
		broken_packets = 0;
		fields_rewritten = 0;
	endfunction

	function void clear_packet();
		byte_count = '0;
		header_words = '0;
		ack_seen = 1'b0;
		syn_seen = 1'b0;
		walk = WALK_KIND;
		opt_kind = '0;
		opt_len = '0;
		opt_pos = '0;
		held = '0;
		held_cnt = 0;
		broken = 1'b0;
	endfunction

	function int unsigned outstanding();
		return expected_bytes.size();
	endfunction

	// Runs one accepted header byte through the parser and queues the bytes it releases.
	function void note_input(hdr_beat_t beat);
		logic [5:0]  pos;
		logic [7:0]  b;
		logic        orig;
		int unsigned hlen;
		int unsigned remaining;
		field_op_e   op;
		logic [31:0] arg;
		logic [31:0] word;
		out_beat_t   grp[$];

		pos = byte_count;
		b = beat.hdr_byte;
		orig = beat.from_origin;
		op = FIELD_PASS;
		arg = '0;
		bytes_in++;

		// Fixed header fields: sequence and ack numbers, data offset, flags.
		if (pos >= POS_SEQ_FIRST && pos < POS_ACK_FIRST) begin
			op = orig ? FIELD_ADD : FIELD_SUB;
			arg = orig ? beat.origin_seq_offset : beat.reverse_seq_offset;
		end else if (pos >= POS_ACK_FIRST && pos < POS_ACK_END) begin
			op = orig ? FIELD_ADD : FIELD_SUB;
			arg = orig ? beat.reverse_seq_offset : beat.origin_seq_offset;
		end else if (pos == POS_DATA_OFFSET) begin
			header_words = b[7:4];
		end else if (pos == POS_FLAGS) begin
			ack_seen = b[4];
			syn_seen = b[1];
		end

		// Option walk inside the header area.
		hlen = (header_words >= MIN_HEADER_WORDS) ? int'(header_words) * 4 : 20;
		if (pos >= POS_OPTIONS && pos < hlen && walk != WALK_DONE) begin
			remaining = hlen - pos;
			case (walk)
				WALK_KIND: begin
					if (b == OPT_KIND_END) begin
						walk = WALK_DONE;
					end else if (b == OPT_KIND_PAD) begin
						walk = WALK_KIND;
					end else if (remaining < 2) begin
						broken = 1'b1;
						walk = WALK_DONE;
					end else begin
						opt_kind = b;
						walk = WALK_LEN;
					end
				end
				WALK_LEN: begin
					if (b < 2 || b > remaining + 1) begin
						broken = 1'b1;
						walk = WALK_DONE;
					end else begin
						opt_len = b;
						opt_pos = 6'd2;
						walk = (b == 8'd2) ? WALK_KIND : WALK_BODY;
					end
				end
				default: begin
					if (opt_kind == OPT_KIND_TSTAMP && opt_len == OPT_LEN_TSTAMP) begin
						// The value moves by the own side's offset, the echo by the other side's.
						if (opt_pos < 6) begin
							op = FIELD_SUB;
							arg = orig ? beat.origin_ts_offset : beat.reverse_ts_offset;
						end else if (ack_seen) begin
							op = FIELD_ADD;
							arg = orig ? beat.reverse_ts_offset : beat.origin_ts_offset;
						end
					end else if (opt_kind == OPT_KIND_SACK && !syn_seen &&
							opt_len >= SACK_MIN_LEN &&
							((opt_len - 8'd2) % SACK_PAIR_LEN) == 0) begin
						op = orig ? FIELD_ADD : FIELD_SUB;
						arg = orig ? beat.reverse_seq_offset : beat.origin_seq_offset;
					end
					opt_pos = opt_pos + 6'd1;
					if ({2'b00, opt_pos} == opt_len)
						walk = WALK_KIND;
				end
			endcase
		end

		// Rewritten fields are held until their fourth byte or the packet's last byte; anything else flushes.
		if (op != FIELD_PASS) begin
			held = {held[23:0], b};
			held_cnt++;
			if (held_cnt == 4) begin
				word = (op == FIELD_ADD) ? held + arg : held - arg;
				for (int i = 3; i >= 0; i--)
					grp.push_back('{word[8*i +: 8], 1'b0, 1'b0});
				held_cnt = 0;
				fields_rewritten++;
			end else if (beat.byte_last) begin
				for (int i = held_cnt; i > 0; i--)
					grp.push_back('{held[8*(i-1) +: 8], 1'b0, 1'b0});
				held_cnt = 0;
			end
		end else begin
			for (int i = held_cnt; i > 0; i--)
				grp.push_back('{held[8*(i-1) +: 8], 1'b0, 1'b0});
			held_cnt = 0;
			grp.push_back('{b, 1'b0, 1'b0});
		end

		if (byte_count < POS_MAX)
			byte_count = byte_count + 6'd1;

		// The final byte of a packet carries the error flag and resets the parser.
		if (beat.byte_last) begin
			if (grp.size() > 0) begin
				grp[grp.size()-1].last = 1'b1;
				grp[grp.size()-1].err = broken;
			end
			packets++;
			if (broken)
				broken_packets++;
			clear_packet();
		end
		foreach (grp[i])
			expected_bytes.push_back(grp[i]);
	endfunction

	// Compares one accepted result beat with the oldest expected byte.
	function void check_result(longint stamp, logic [7:0] data, logic last, logic err);
		out_beat_t want;

		bytes_out++;
		if (expected_bytes.size() == 0) begin
			$display("%0d ns: unexpected result beat, got byte %02h last %b err %b",
				stamp, data, last, err);
			errors++;
			return;
		end
		want = expected_bytes.pop_front();
		if (data !== want.data) begin
			$display("%0d ns: out_byte expected %02h, got %02h", stamp, want.data, data);
			errors++;
		end
		if (last !== want.last) begin
			$display("%0d ns: out_last expected %b, got %b", stamp, want.last, last);
			errors++;
		end
		if (err !== want.err) begin
			$display("%0d ns: options_error expected %b, got %b", stamp, want.err, err);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned ITEM_TARGET = 150;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam logic [7:0] FLAG_ACK = 8'h10;
	localparam logic [7:0] FLAG_SYN = 8'h02;

	logic clk;
	logic arst_n;
	int unsigned cycle_count = 0;
	logic [7:0] pkt[$];

	rewrite_tracker tracker = new();

	tss_in_if hdr();
	tss_out_if res();

	tcp_splice_seq_rewriter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr),
		.res    (res)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d bytes outstanding",
				cycle_count, tracker.outstanding());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random stalls, every accepted beat is checked.
	initial begin
		int gap;

		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			tracker.check_result($time, res.out_byte, res.out_last, res.options_error);
		end
	end

	// Drives one header byte after a random gap and waits for its handshake.
	task automatic push_beat(input hdr_beat_t beat);
		int gap;

		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			hdr.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr.valid <= 1'b1;
		hdr.hdr_byte <= beat.hdr_byte;
		hdr.byte_last <= beat.byte_last;
		hdr.from_origin <= beat.from_origin;
		hdr.origin_seq_offset <= beat.origin_seq_offset;
		hdr.reverse_seq_offset <= beat.reverse_seq_offset;
		hdr.origin_ts_offset <= beat.origin_ts_offset;
		hdr.reverse_ts_offset <= beat.reverse_ts_offset;
		do @(posedge clk); while (!hdr.ready);
		tracker.note_input(beat);
	endtask

	// Sends the bytes collected in pkt as one packet.
	task automatic send_packet(input logic orig, input logic [31:0] o_seq, r_seq, o_ts, r_ts);
		hdr_beat_t beat;

		for (int i = 0; i < pkt.size(); i++) begin
			beat.hdr_byte = pkt[i];
			beat.byte_last = (i == pkt.size() - 1);
			beat.from_origin = orig;
			beat.origin_seq_offset = o_seq;
			beat.reverse_seq_offset = r_seq;
			beat.origin_ts_offset = o_ts;
			beat.reverse_ts_offset = r_ts;
			push_beat(beat);
		end
	endtask

	task automatic wait_drained();
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			pkt.push_back(w[8*i +: 8]);
	endtask

	task automatic push_random(input int count);
		repeat (count) pkt.push_back(8'($urandom()));
	endtask

	// Fixed 20-byte header with the given numbers, data offset and flags.
	task automatic start_header(input logic [31:0] seq, ack, input logic [3:0] words,
			input logic [7:0] flags);
		pkt.delete();
		push_random(4);
		push_word(seq);
		push_word(ack);
		pkt.push_back({words, 4'($urandom())});
		pkt.push_back(flags);
		push_random(6);
	endtask

	task automatic truncate_packet(input int keep);
		while (pkt.size() > keep) void'(pkt.pop_back());
	endtask

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Fills an option area of the given size, mostly well formed.
	task automatic add_options(input int area);
		int left;
		int sel;
		int blocks;
		int len;

		left = area;
		while (left > 0) begin
			sel = $urandom_range(0, 99);
			if (left == 1) begin
				// A kind byte here has no room for its length.
				if (sel < 80)
					pkt.push_back(OPT_KIND_PAD);
				else
					pkt.push_back(8'($urandom_range(2, 255)));
				left = 0;
			end else if (sel < 30 && left >= 10) begin
				pkt.push_back(OPT_KIND_TSTAMP);
				pkt.push_back(OPT_LEN_TSTAMP);
				push_random(8);
				left -= 10;
			end else if (sel < 50 && left >= 10) begin
				blocks = $urandom_range(1, ((left - 2) / 8 > 4) ? 4 : (left - 2) / 8);
				pkt.push_back(OPT_KIND_SACK);
				pkt.push_back(8'(2 + 8 * blocks));
				push_random(8 * blocks);
				left -= 2 + 8 * blocks;
			end else if (sel < 65) begin
				pkt.push_back(OPT_KIND_PAD);
				left -= 1;
			end else if (sel < 80) begin
				len = $urandom_range(2, (left > 12) ? 12 : left);
				pkt.push_back(8'($urandom_range(2, 255)));
				pkt.push_back(8'(len));
				push_random(len - 2);
				left -= len;
			end else if (sel < 88) begin
				// End of list, then padding that must pass untouched.
				pkt.push_back(OPT_KIND_END);
				if ($urandom_range(0, 1))
					repeat (left - 1) pkt.push_back(8'h00);
				else
					push_random(left - 1);
				left = 0;
			end else if (sel < 94) begin
				// Timestamp or SACK kind with a random length, rewritten only where it fits.
				len = $urandom_range(2, (left > 18) ? 18 : left);
				pkt.push_back($urandom_range(0, 1) ? OPT_KIND_TSTAMP : OPT_KIND_SACK);
				pkt.push_back(8'(len));
				push_random(len - 2);
				left -= len;
			end else begin
				// Malformed length: below two or past the end of the area.
				pkt.push_back(8'($urandom_range(2, 255)));
				if ($urandom_range(0, 1))
					pkt.push_back(8'($urandom_range(0, 1)));
				else
					pkt.push_back(8'($urandom_range(left + 1, 255)));
				push_random(left - 2);
				left = 0;
			end
		end
	endtask

	// One random packet: mostly well-formed headers with random content, some noise.
	task automatic send_random_packet();
		int sel;
		logic [3:0] words;

		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			pkt.delete();
			push_random($urandom_range(1, 40));
		end else begin
			words = ($urandom_range(0, 99) < 8) ? 4'($urandom_range(0, 4))
				: 4'($urandom_range(5, 15));
			start_header($urandom(), $urandom(), words, 8'($urandom()));
			if (words >= MIN_HEADER_WORDS)
				add_options(int'(words) * 4 - 20);
			if ($urandom_range(0, 19) == 0)
				push_random($urandom_range(20, 50));
			else
				push_random($urandom_range(0, 3));
			// Sometimes the packet ends in the middle of a field.
			if ($urandom_range(0, 99) < 10)
				truncate_packet($urandom_range(1, pkt.size()));
		end
		send_packet(1'($urandom_range(0, 1)), pick_offset(), pick_offset(), pick_offset(),
			pick_offset());
	endtask

	// Directed packets over the fields' extremes and each parsing corner.
	task automatic send_directed();
		// Sequence number wraps upward and ack moves up, origin direction, with NOPs, a timestamp,
		// one SACK block, an empty option and end of list.
		start_header(32'hFFFF_FFF0, 32'h0000_0005, 4'd12, FLAG_ACK);
		pkt.push_back(OPT_KIND_PAD);
		pkt.push_back(OPT_KIND_PAD);
		pkt.push_back(OPT_KIND_TSTAMP);
		pkt.push_back(OPT_LEN_TSTAMP);
		push_word(32'h0000_0001);
		push_word(32'hFFFF_FFF0);
		pkt.push_back(OPT_KIND_SACK);
		pkt.push_back(8'd10);
		push_word(32'h0000_0000);
		push_word(32'hFFFF_FFFF);
		pkt.push_back(8'd4);
		pkt.push_back(8'd2);
		pkt.push_back(OPT_KIND_END);
		push_random(3);
		send_packet(1'b1, 32'hFFFF_FFFF, 32'h0000_0020, 32'h0000_0100, 32'h8000_0001);

		// SYN without ACK, reverse direction, wrapping downward: the timestamp echo
		// and the SACK block pass unchanged.
		start_header(32'h0000_0003, 32'hFFFF_FFFE, 4'd10, FLAG_SYN);
		pkt.push_back(OPT_KIND_TSTAMP);
		pkt.push_back(OPT_LEN_TSTAMP);
		push_word(32'h0000_0010);
		push_word(32'h0000_0020);
		pkt.push_back(OPT_KIND_SACK);
		pkt.push_back(8'd10);
		push_random(8);
		send_packet(1'b0, 32'h0000_0010, 32'hFFFF_FFFF, 32'h0000_0030, 32'hFFFF_FFF0);

		// Option length past the end of the area, on the packet's last byte.
		start_header($urandom(), $urandom(), 4'd6, FLAG_ACK);
		pkt.push_back(8'd3);
		pkt.push_back(8'd5);
		send_packet(1'b1, pick_offset(), pick_offset(), pick_offset(), pick_offset());

		// Kind byte on the last byte of the area.
		start_header($urandom(), $urandom(), 4'd6, 8'h00);
		pkt.push_back(OPT_KIND_PAD);
		pkt.push_back(OPT_KIND_PAD);
		pkt.push_back(OPT_KIND_PAD);
		pkt.push_back(8'd3);
		send_packet(1'b0, pick_offset(), pick_offset(), pick_offset(), pick_offset());

		// Packet ends inside the sequence number.
		start_header(32'hDEAD_BEEF, 32'h0, 4'd5, FLAG_ACK);
		truncate_packet(6);
		send_packet(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);

		// Single-byte packet.
		pkt.delete();
		pkt.push_back(8'hFF);
		send_packet(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
	endtask

	// Stimulus.
	initial begin
		arst_n = 1'b0;
		hdr.valid = 1'b0;
		hdr.hdr_byte = '0;
		hdr.byte_last = 1'b0;
		hdr.from_origin = 1'b0;
		hdr.origin_seq_offset = '0;
		hdr.reverse_seq_offset = '0;
		hdr.origin_ts_offset = '0;
		hdr.reverse_ts_offset = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets, then the sender waits for every result.
		send_directed();
		hdr.valid <= 1'b0;
		wait_drained();

		// Random packets until the byte budget is spent.
		while (tracker.bytes_in < ITEM_TARGET)
			send_random_packet();
		hdr.valid <= 1'b0;

		// Let the last bytes drain, then watch for stray results.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d packets, %0d header bytes in and %0d bytes out.",
			tracker.packets, tracker.bytes_in, tracker.bytes_out);
		$display("Rewrote %0d 32-bit fields; %0d packets carried a malformed option.",
			tracker.fields_rewritten, tracker.broken_packets);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
